### rtl/mrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and constants for the matrix rotate unit
// Element width, store geometry and the request carried from the front end
// to the back end.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int MaxSize    = 8;
  localparam int StoreDepth = MaxSize * MaxSize;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int IdxW       = $clog2(MaxSize);
  localparam int SizeW      = 4;
  localparam int ElemW      = 32;
  localparam int QueueDepth = 2;

  // One loaded element, with its place in the store.
  typedef struct packed {
    logic signed [ElemW-1:0] value;
    logic [AddrW-1:0]        addr;
    logic                    last;
  } elem_req_t;

endpackage
`default_nettype wire

### rtl/mrc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_front: element loader
// Accepts elements, numbers them in row-major order and marks the last
// element of the matrix before handing them to the request queue.
// ----------------------------------------------------------------------------
module mrc_front
  import mrc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [IdxW-1:0]         n_m1,
  input  wire logic                    restart,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [ElemW-1:0] element_value,
  input  wire logic                    q_full,
  output logic                         q_push,
  output elem_req_t                    q_data
);

  logic [AddrW-1:0] load_count;
  logic [IdxW:0]    n_val;
  logic [2*IdxW+1:0] n_sq;
  logic [AddrW-1:0] total_m1;
  logic             is_last;

  assign n_val    = {1'b0, n_m1} + (IdxW+1)'(1);
  assign n_sq     = {{(IdxW+1){1'b0}}, n_val} * {{(IdxW+1){1'b0}}, n_val};
  assign total_m1 = AddrW'(n_sq - (2*IdxW+2)'(1));
  assign is_last  = (load_count == total_m1);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = '{value: element_value, addr: load_count, last: is_last};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      load_count <= '0;
    end else if (q_push) begin
      load_count <= is_last ? '0 : load_count + AddrW'(1);
    end
  end

endmodule
`default_nettype wire

### rtl/mrc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_queue: request queue
// Short first-in first-out buffer between the loader and the emitter.
// ----------------------------------------------------------------------------
module mrc_queue
  import mrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire elem_req_t push_data,
  input  wire logic      pop,
  output elem_req_t      pop_data,
  output logic           full,
  output logic           empty
);

  localparam int PtrW = $clog2(QueueDepth);

  elem_req_t       slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full     = (count == (PtrW+1)'(QueueDepth));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth-1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth-1)) ? '0 : rd_ptr + PtrW'(1);
      end
      count <= count + (PtrW+1)'(push && !full) - (PtrW+1)'(pop && !empty);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("request pushed into a full queue");
  assert property (@(posedge clk) disable iff (rst) count <= (PtrW+1)'(QueueDepth))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

### rtl/mrc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_back: store and emitter
// Writes queued elements into the store; after the last element of a matrix
// reads it back column by column from the bottom, giving the rotated matrix.
// ----------------------------------------------------------------------------
module mrc_back
  import mrc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [IdxW-1:0]         n_m1,
  input  wire elem_req_t               q_data,
  input  wire logic                    q_empty,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [ElemW-1:0]      rotated_value,
  output logic                         last_of_matrix
);

  typedef enum logic [1:0] {
    ST_DRAIN,
    ST_READ,
    ST_SHOW
  } state_t;

  state_t                  state;
  logic [IdxW-1:0]         row;
  logic [IdxW-1:0]         col;
  logic                    last_flag;
  logic signed [ElemW-1:0] store [StoreDepth];
  logic signed [ElemW-1:0] rd_data;
  logic [IdxW:0]           n_val;
  logic [IdxW-1:0]         src_row;
  logic [2*IdxW+1:0]       src_base;
  logic [AddrW-1:0]        rd_addr;
  logic                    at_end;

  assign n_val    = {1'b0, n_m1} + (IdxW+1)'(1);
  // Output (row, col) comes from input (n-1-col, row).
  assign src_row  = n_m1 - col;
  assign src_base = {{(IdxW+2){1'b0}}, src_row} * {{(IdxW+1){1'b0}}, n_val};
  assign rd_addr  = AddrW'(src_base + {{(IdxW+2){1'b0}}, row});
  assign at_end   = (row == n_m1) && (col == n_m1);

  assign q_pop          = (state == ST_DRAIN) && !q_empty;
  assign out_valid      = (state == ST_SHOW);
  assign rotated_value  = rd_data;
  assign last_of_matrix = last_flag;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      store[q_data.addr] <= q_data.value;
    end
    if (state == ST_READ) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_DRAIN;
      row       <= '0;
      col       <= '0;
      last_flag <= 1'b0;
    end else begin
      case (state)
        ST_DRAIN: begin
          if (q_pop && q_data.last) begin
            row   <= '0;
            col   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          last_flag <= at_end;
          state     <= ST_SHOW;
        end
        ST_SHOW: begin
          if (!out_stall) begin
            if (last_flag) begin
              state <= ST_DRAIN;
            end else begin
              // advance in row-major order of the rotated matrix
              if (col == n_m1) begin
                col <= '0;
                row <= row + IdxW'(1);
              end else begin
                col <= col + IdxW'(1);
              end
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_DRAIN;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == ST_READ) |=> (state == ST_SHOW))
    else $error("store read not followed by a result");
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !out_stall && last_of_matrix) |=> (state == ST_DRAIN))
    else $error("emitter did not return to draining after the last result");

endmodule
`default_nettype wire

### rtl/matrix_rotate_clockwise_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_rotate_clockwise_unit: 90 degree clockwise matrix rotation
// Loads an n x n matrix in row-major order and emits it turned clockwise,
// also row-major, flagging the final element.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   input    | in        | in_valid / in_stall | element_value
//   output   | out       | out_valid/out_stall | rotated_value, last_of_matrix
//   config   | in        | matrix_size_we      | matrix_size
//
// Loading accepts one element per cycle while the request queue has room.
// Each rotated element is a store read, then the result is shown; the next
// read starts only once the shown result is taken (out_stall low).
// Reset clears control state only; the element store has no clearing pass.
// A stalled output holds the emitter; the loader keeps taking elements until
// the two-entry queue fills, then raises in_stall.
// ----------------------------------------------------------------------------
module matrix_rotate_clockwise_unit
  import mrc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    matrix_size_we,
  input  wire logic [SizeW-1:0]        matrix_size,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [ElemW-1:0] element_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [ElemW-1:0]      rotated_value,
  output logic                         last_of_matrix
);

  logic [SizeW-1:0] size_reg;
  logic [IdxW-1:0]  n_m1;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  elem_req_t        q_in;
  elem_req_t        q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SizeW'(MaxSize);
    end else if (matrix_size_we) begin
      size_reg <= matrix_size;
    end
  end

  // clamp the size into 1..MaxSize
  always_comb begin
    if (size_reg == '0) begin
      n_m1 = '0;
    end else if (size_reg > SizeW'(MaxSize)) begin
      n_m1 = IdxW'(MaxSize - 1);
    end else begin
      n_m1 = IdxW'(size_reg - SizeW'(1));
    end
  end

  mrc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .n_m1          (n_m1),
    .restart       (matrix_size_we),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_value (element_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  mrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  mrc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .n_m1           (n_m1),
    .q_data         (q_out),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .rotated_value  (rotated_value),
    .last_of_matrix (last_of_matrix)
  );

endmodule
`default_nettype wire
